[design/wnp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnp_pkg
// Shared types and constants of the nearest feature point distance block.
// ----------------------------------------------------------------------------
package wnp_pkg;

	localparam int MAX_CELLS_AXIS_DEF = 16;
	localparam int COORD_BITS_DEF     = 16;
	localparam int TABLE_DEPTH        = 256;
	localparam int IDX_W              = 8;
	localparam int CELL_W             = 5;
	localparam int NB                 = 9;

	localparam logic [CELL_W-1:0] CELLS_RESET = CELL_W'(8);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// per-neighbor handling of one query
	typedef struct packed {
		logic skip;   // outside the grid, no wrap
		logic fold;   // outside the grid, wrapped: try all unit shifts
	} nb_t;

endpackage

[design/wnp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnp_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wnp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read returns old data on an address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[design/wnp_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnp_dist
// Squared distances to the nine neighbor points and their minimum, 5 stages.
// ----------------------------------------------------------------------------
module wnp_dist #(
	parameter int COORD_BITS = wnp_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COORD_BITS-1:0]   sample_x,
	input  logic [COORD_BITS-1:0]   sample_y,
	input  wnp_pkg::nb_t            nb [wnp_pkg::NB],
	input  logic [COORD_BITS-1:0]   px [wnp_pkg::NB],
	input  logic [COORD_BITS-1:0]   py [wnp_pkg::NB],
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2*COORD_BITS:0]   best
);
	import wnp_pkg::*;

	localparam int F  = COORD_BITS;
	localparam int DW = 2 * F + 1;
	localparam logic [DW-1:0] ONE_SQ = DW'(1) << (2 * F);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [F-1:0]    ax_s1  [NB];
	logic [F-1:0]    ay_s1  [NB];
	logic [NB-1:0]   skip_s1;
	logic [2*F-1:0]  sqx_s2 [NB];
	logic [2*F-1:0]  sqy_s2 [NB];
	logic [NB-1:0]   skip_s2;
	logic [DW-1:0]   d_s3   [NB];
	logic [DW-1:0]   m_s4   [3];
	logic [DW-1:0]   best_s5;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// absolute axis distances; a wrapped point takes the nearer unit shift
	function automatic logic [F-1:0] axis_dist(input logic [F-1:0] s,
			input logic [F-1:0] p, input logic fold);
		logic [F:0] d;
		logic [F:0] a;
		logic [F:0] c;
		d = {1'b0, s} - {1'b0, p};
		a = d[F] ? (~d + (F+1)'(1)) : d;
		c = ((F+1)'(1) << F) - a;
		if (fold && (c < a)) begin
			a = c;
		end
		return a[F-1:0];
	endfunction

	for (genvar n = 0; n < NB; n++) begin : g_nb
		always_ff @(posedge clk) begin
			if (rdy1) begin
				ax_s1[n]   <= axis_dist(sample_x, px[n], nb[n].fold);
				ay_s1[n]   <= axis_dist(sample_y, py[n], nb[n].fold);
				skip_s1[n] <= nb[n].skip;
			end
			if (rdy2) begin
				sqx_s2[n]  <= ax_s1[n] * ax_s1[n];
				sqy_s2[n]  <= ay_s1[n] * ay_s1[n];
				skip_s2[n] <= skip_s1[n];
			end
			if (rdy3) begin
				d_s3[n] <= skip_s2[n] ? ONE_SQ
					: ({1'b0, sqx_s2[n]} + {1'b0, sqy_s2[n]});
			end
		end
	end

	function automatic logic [DW-1:0] min2(input logic [DW-1:0] a,
			input logic [DW-1:0] b);
		return (b < a) ? b : a;
	endfunction

	always_ff @(posedge clk) begin
		if (rdy4) begin
			m_s4[0] <= min2(min2(d_s3[0], d_s3[1]), d_s3[2]);
			m_s4[1] <= min2(min2(d_s3[3], d_s3[4]), d_s3[5]);
			m_s4[2] <= min2(min2(d_s3[6], d_s3[7]), d_s3[8]);
		end
		if (rdy5) begin
			best_s5 <= min2(min2(min2(m_s4[0], m_s4[1]), m_s4[2]), ONE_SQ);
		end
	end

	assign out_valid = v_s5;
	assign best      = best_s5;

`ifndef SYNTHESIS
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> best_s5 <= ONE_SQ)
		else $error("minimum above 1.0");
	a_skip_max: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy3 && v_s2 && skip_s2 == '1) |=> d_s3[0] == ONE_SQ)
		else $error("skipped neighbor not at 1.0");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !out_ready) |=> $stable(best_s5))
		else $error("minimum changed under stall");
`endif
endmodule

[design/wnp_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnp_isqrt
// Pipelined integer square root, one root bit per stage, truncating.
// ----------------------------------------------------------------------------
module wnp_isqrt #(
	parameter int COORD_BITS = wnp_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2*COORD_BITS:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS:0]   root
);
	localparam int RB = COORD_BITS + 1;
	localparam int VW = 2 * RB;

	logic [RB:0]    rem_s  [RB];
	logic [RB-1:0]  root_s [RB];
	logic [VW-1:0]  val_s  [RB];
	logic [RB-1:0]  vld_s;
	logic [RB:0]    rdy;

	assign rdy[RB]  = out_ready;
	assign in_ready = rdy[0];

	for (genvar s = 0; s < RB; s++) begin : g_st
		logic [RB:0]   prem;
		logic [RB-1:0] proot;
		logic [VW-1:0] pval;
		logic          pvld;
		logic [RB+2:0] rn;
		logic [RB+2:0] t;
		logic          ge;

		if (s == 0) begin : g_first
			assign prem  = '0;
			assign proot = '0;
			assign pval  = {1'b0, value};
			assign pvld  = in_valid;
		end else begin : g_next
			assign prem  = rem_s[s-1];
			assign proot = root_s[s-1];
			assign pval  = val_s[s-1];
			assign pvld  = vld_s[s-1];
		end

		assign rn = {prem, pval[VW-1 -: 2]};
		assign t  = {1'b0, proot, 2'b01};
		assign ge = rn >= t;

		assign rdy[s] = !vld_s[s] || rdy[s+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (rdy[s]) begin
				vld_s[s] <= pvld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[s]) begin
				rem_s[s]  <= ge ? (rn[RB:0] - t[RB:0]) : rn[RB:0];
				root_s[s] <= {proot[RB-2:0], ge};
				val_s[s]  <= pval << 2;
			end
		end
	end

	assign out_valid = vld_s[RB-1];
	assign root      = root_s[RB-1];

`ifndef SYNTHESIS
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> root <= (RB'(1) << (RB - 1)))
		else $error("root above 1.0");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> rem_s[0] <= (RB+1)'(2))
		else $error("first remainder out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(root)))
		else $error("root lost under stall");
`endif
endmodule

[design/worley_nearest_point_distance_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worley_nearest_point_distance_top
// Nearest feature point distance of 2-D cellular noise over a point table.
// ----------------------------------------------------------------------------
// One item enters per cycle while the result side does not stall, writes and
// queries alike. Three front stages find the cell and read the nine neighbor
// points, five stages form and reduce the squared distances, and the square
// root takes one stage per result bit. The point table is held in nine copies,
// one read port per neighbor, all written together. A write item is taken at
// once, passes the first two front stages in order with the queries around
// it, is written to the table as it leaves the second, and returns nothing; a
// query reading an entry never written gives no defined distance. Stalls on
// the result side back up the stages without loss.
module worley_nearest_point_distance_top #(
	parameter int COORD_BITS     = wnp_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// sample_x, sample_y, wrap_mode, point_index, point_x, point_y, zero pad
	input  logic [((4*COORD_BITS+10+7)/8)*8-1:0]   s_tdata,
	// op
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// distance, zero pad
	output logic [((COORD_BITS+1+7)/8)*8-1:0]      m_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [wnp_pkg::CELL_W-1:0]             cfg_data
);
	import wnp_pkg::*;

	localparam int F      = COORD_BITS;
	localparam int ODW    = ((F + 1 + 7) / 8) * 8;
	localparam int SY_LO  = F;
	localparam int WRAP_B = 2 * F;
	localparam int IDX_LO = 2 * F + 1;
	localparam int PX_LO  = 2 * F + 1 + IDX_W;
	localparam int PY_LO  = 3 * F + 1 + IDX_W;
	localparam int SW     = CELL_W + 2;

	logic [CELL_W-1:0] cells_q;
	logic [CELL_W-1:0] cells_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= CELLS_RESET;
		end else if (cfg_valid) begin
			cells_q <= cfg_data;
		end
	end

	always_comb begin
		if (cells_q == '0) begin
			cells_eff = CELL_W'(1);
		end else if (32'(cells_q) > MAX_CELLS_AXIS_DEF) begin
			cells_eff = CELL_W'(MAX_CELLS_AXIS_DEF);
		end else begin
			cells_eff = cells_q;
		end
	end

	logic in_acc;
	logic wr_en;
	assign in_acc = s_tvalid && s_tready;

	logic v_s1, v_s2, v_s3;
	logic w_s1, w_s2;
	logic rdy1, rdy2, rdy3;
	logic dist_ready;

	logic [F-1:0]      sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3;
	logic              wrap_s1, wrap_s2;
	logic [CELL_W-1:0] cells_s1, cells_s2;
	logic [CELL_W-1:0] cx_s2, cy_s2;
	logic [IDX_W-1:0]  widx_s1, widx_s2;
	logic [2*F-1:0]    wpt_s1, wpt_s2;
	nb_t               nb_s3 [NB];
	logic [F-1:0]      px_rd [NB];
	logic [F-1:0]      py_rd [NB];

	assign rdy3     = !v_s3 || dist_ready;
	assign rdy2     = !(v_s2 || w_s2) || rdy3;
	assign rdy1     = !(v_s1 || w_s1) || rdy2;
	assign s_tready = rdy1;

	// a write lands on the edge where it would pass the table read
	assign wr_en = w_s2 && rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			w_s1 <= 1'b0;
			w_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_acc && (s_tuser == OP_QUERY);
			if (rdy1) w_s1 <= in_acc && (s_tuser == OP_WRITE);
			if (rdy2) v_s2 <= v_s1;
			if (rdy2) w_s2 <= w_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	logic [F+CELL_W-1:0] cxp, cyp;
	assign cxp = {{CELL_W{1'b0}}, sx_s1} * {{F{1'b0}}, cells_s1};
	assign cyp = {{CELL_W{1'b0}}, sy_s1} * {{F{1'b0}}, cells_s1};

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sx_s1    <= s_tdata[F-1:0];
			sy_s1    <= s_tdata[SY_LO +: F];
			wrap_s1  <= s_tdata[WRAP_B];
			cells_s1 <= cells_eff;
			widx_s1  <= s_tdata[IDX_LO +: IDX_W];
			wpt_s1   <= {s_tdata[PY_LO +: F], s_tdata[PX_LO +: F]};
		end
		if (rdy2) begin
			sx_s2    <= sx_s1;
			sy_s2    <= sy_s1;
			wrap_s2  <= wrap_s1;
			cells_s2 <= cells_s1;
			cx_s2    <= cxp[F +: CELL_W];
			cy_s2    <= cyp[F +: CELL_W];
			widx_s2  <= widx_s1;
			wpt_s2   <= wpt_s1;
		end
		if (rdy3) begin
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
		end
	end

	for (genvar n = 0; n < NB; n++) begin : g_nb
		localparam int OX = (n % 3) - 1;
		localparam int OY = (n / 3) - 1;

		logic signed [SW-1:0]  ax, ay, cs;
		logic                  edge_x, edge_y, outside;
		logic [CELL_W-1:0]     wx, wy;
		logic [2*CELL_W-1:0]   idx_full;
		logic [IDX_W-1:0]      raddr;
		logic [2*F-1:0]        rdata;

		assign cs     = $signed({2'b00, cells_s2});
		assign ax     = $signed({2'b00, cx_s2}) + SW'(OX);
		assign ay     = $signed({2'b00, cy_s2}) + SW'(OY);
		assign edge_x = (ax == '1) || (ax == cs);
		assign edge_y = (ay == '1) || (ay == cs);
		assign outside = edge_x || edge_y;

		// a step past either side comes back in on the other side
		assign wx = (ax == '1) ? (cells_s2 - CELL_W'(1))
			: (ax == cs) ? '0 : ax[CELL_W-1:0];
		assign wy = (ay == '1) ? (cells_s2 - CELL_W'(1))
			: (ay == cs) ? '0 : ay[CELL_W-1:0];

		assign idx_full = ({{CELL_W{1'b0}}, cells_s2} * {{CELL_W{1'b0}}, wy})
			+ {{CELL_W{1'b0}}, wx};
		assign raddr = idx_full[IDX_W-1:0];

		always_ff @(posedge clk) begin
			if (rdy3) begin
				nb_s3[n].skip <= outside && !wrap_s2;
				nb_s3[n].fold <= outside && wrap_s2;
			end
		end

		wnp_ram #(
			.WIDTH (2 * F),
			.DEPTH (TABLE_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (widx_s2),
			.wdata (wpt_s2),
			.re    (rdy3),
			.raddr (raddr),
			.rdata (rdata)
		);

		assign px_rd[n] = rdata[F-1:0];
		assign py_rd[n] = rdata[2*F-1:F];
	end

	logic           best_valid, best_ready;
	logic [2*F:0]   best;
	logic [F:0]     root;

	wnp_dist #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (dist_ready),
		.sample_x  (sx_s3),
		.sample_y  (sy_s3),
		.nb        (nb_s3),
		.px        (px_rd),
		.py        (py_rd),
		.out_valid (best_valid),
		.out_ready (best_ready),
		.best      (best)
	);

	wnp_isqrt #(
		.COORD_BITS (COORD_BITS)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (best_valid),
		.in_ready  (best_ready),
		.value     (best),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.root      (root)
	);

	assign m_tdata = ODW'(root);

`ifndef SYNTHESIS
	a_query_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == OP_QUERY) |=> v_s1)
		else $error("query item not taken into the pipeline");
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == OP_WRITE) |=> !v_s1)
		else $error("write item entered the pipeline");
	a_front_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 || w_s1) |-> s_tready)
		else $error("input stalled with empty front stage");
	a_cells_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (cx_s2 < cells_s2 && cy_s2 < cells_s2))
		else $error("sample cell outside the grid");
`endif
endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest feature point distance block.
// ----------------------------------------------------------------------------
// The point table is filled first, so no query ever reads an unwritten entry.
// Directed queries hit the coordinate extremes, the edge cells with and
// without wrap, and the smallest and largest grids. Random write/query traffic
// then runs under several idle and stall mixes. A long sink hold-off fills the
// pipe. Each distance is checked against an in-bench predictor.
module tb_top;
	import wnp_pkg::*;

	localparam int DW = 80;
	localparam int RW = 24;
	localparam int DRAIN = 40;

	typedef struct packed {
		logic [15:0] point_y;
		logic [15:0] point_x;
		logic [7:0]  point_index;
		logic        wrap_mode;
		logic [15:0] sample_y;
		logic [15:0] sample_x;
	} item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RW-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CELL_W-1:0] cfg_data = '0;

	logic [15:0] pts_x [TABLE_DEPTH];
	logic [15:0] pts_y [TABLE_DEPTH];
	logic [CELL_W-1:0] grid_cells = CELLS_RESET;
	logic [16:0] dist_queue [$];
	int errors = 0;
	int queries = 0;
	int writes = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_cycles = 0;

	worley_nearest_point_distance_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned sq_dist(longint sx, longint sy, longint px, longint py);
		return (sx - px) * (sx - px) + (sy - py) * (sy - py);
	endfunction

	function automatic logic [16:0] nearest_distance(item_t it);
		longint n, sx, sy, cx, cy, ax, ay, wx, wy, px, py;
		longint unsigned best, d;
		int idx;
		n = (grid_cells == 0) ? 1 : (grid_cells > 16 ? 16 : grid_cells);
		sx = it.sample_x;
		sy = it.sample_y;
		cx = (sx * n) >> 16;
		cy = (sy * n) >> 16;
		best = 64'd1 << 32;
		for (int oy = -1; oy <= 1; oy++) begin
			for (int ox = -1; ox <= 1; ox++) begin
				ax = cx + ox;
				ay = cy + oy;
				if (ax == -1 || ay == -1 || ax == n || ay == n) begin
					if (it.wrap_mode) begin
						wx = (ax + n) % n;
						wy = (ay + n) % n;
						idx = int'((wx + n * wy) & 255);
						px = pts_x[idx];
						py = pts_y[idx];
						for (int ty = -1; ty <= 1; ty++)
							for (int tx = -1; tx <= 1; tx++) begin
								d = sq_dist(sx, sy, px + tx * 65536, py + ty * 65536);
								if (d < best)
									best = d;
							end
					end
				end else begin
					idx = int'((ax + n * ay) & 255);
					d = sq_dist(sx, sy, pts_x[idx], pts_y[idx]);
					if (d < best)
						best = d;
				end
			end
		end
		return 17'(int_sqrt(best));
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		$display("mismatch @%0t: %s", $realtime, what);
	endtask

	// sink: random stalls, or a counted hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected distance %0h", m_tdata[16:0]));
			end else begin
				logic [16:0] want;
				want = dist_queue.pop_front();
				if (m_tdata[16:0] !== want)
					report_mismatch($sformatf("distance got %0h want %0h", m_tdata[16:0], want));
			end
		end
	end

	task automatic send_item(logic op, item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= DW'(it);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == OP_WRITE) begin
			pts_x[it.point_index] = it.point_x;
			pts_y[it.point_index] = it.point_y;
			writes++;
		end else begin
			dist_queue.push_back(nearest_distance(it));
			queries++;
		end
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (dist_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_cells(logic [CELL_W-1:0] v);
		go_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		grid_cells = v;
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.sample_x = 16'($urandom);
		it.sample_y = 16'($urandom);
		it.wrap_mode = 1'($urandom);
		it.point_index = 8'($urandom);
		it.point_x = 16'($urandom);
		it.point_y = 16'($urandom);
		case ($urandom_range(7))
			0: it.sample_x = 16'h0000;
			1: it.sample_x = 16'hffff;
			2: it.sample_y = 16'h0000;
			3: it.sample_y = 16'hffff;
			default: ;
		endcase
		return it;
	endfunction

	task automatic send_query(logic [15:0] x, logic [15:0] y, logic w);
		item_t it;
		it = rand_item();
		it.sample_x = x;
		it.sample_y = y;
		it.wrap_mode = w;
		send_item(OP_QUERY, it);
	endtask

	task automatic test_fill_table();
		item_t it;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			it = rand_item();
			it.point_index = 8'(i);
			send_item(OP_WRITE, it);
		end
	endtask

	task automatic test_directed();
		item_t it;
		// extreme points in table entries 0 and 255, and queries from the corners and the centre
		it = rand_item();
		it.point_index = 0; it.point_x = 16'h0000; it.point_y = 16'h0000;
		send_item(OP_WRITE, it);
		it.point_index = 255; it.point_x = 16'hffff; it.point_y = 16'hffff;
		send_item(OP_WRITE, it);
		for (int w = 0; w < 2; w++) begin
			send_query(16'h0000, 16'h0000, 1'(w));
			send_query(16'hffff, 16'hffff, 1'(w));
			send_query(16'h0000, 16'hffff, 1'(w));
			send_query(16'hffff, 16'h0000, 1'(w));
			send_query(16'h8000, 16'h8000, 1'(w));
		end
		// one cell only: every neighbor but the centre one is an edge cell
		set_cells(5'd1);
		for (int w = 0; w < 2; w++) begin
			send_query(16'h0000, 16'h0000, 1'(w));
			send_query(16'hffff, 16'h7fff, 1'(w));
		end
		set_cells(5'd16);
		for (int w = 0; w < 2; w++) begin
			send_query(16'h0000, 16'hffff, 1'(w));
			send_query(16'hffff, 16'hffff, 1'(w));
			send_query(16'h1234, 16'hedcb, 1'(w));
		end
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_item($urandom_range(99) < 70 ? OP_QUERY : OP_WRITE, rand_item());
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_cycles = 300;
		test_random(150);
		// sender pauses until everything has drained
		go_idle();
		test_random(50);
	endtask

	initial begin
		logic [CELL_W-1:0] grids [6];
		int idle_mix [4][2];
		grids = '{5'd8, 5'd1, 5'd16, 5'd3, 5'd5, 5'd12};
		idle_mix = '{'{0, 0}, '{49, 0}, '{0, 49}, '{36, 36}};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_table();
		test_directed();
		for (int p = 0; p < 6; p++) begin
			set_cells(grids[p]);
			src_idle_pct = idle_mix[p % 4][0];
			snk_stall_pct = idle_mix[p % 4][1];
			test_random(250);
		end
		set_cells(5'd7);
		test_backpressure();
		go_idle();
		if (dist_queue.size() != 0)
			report_mismatch("distances still outstanding");
		$display("covered %0d writes, %0d queries over grids of 1 to 16 cells", writes, queries);
		$display("with wrap on and off, idle/stall mixes and a long sink hold-off");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
